// ===== hdl/chatan_pkg.sv =====
// ----------------------------------------------------------------------------
// chatan_pkg
// Shared constants and elaboration-time helpers for the compass heading
// CORDIC: arctangent table, pi and 2*pi rounded to the angle format.
// ----------------------------------------------------------------------------
package chatan_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int FRAC_BITS_DEF     = 13;

  localparam int TABLE_FRAC = 30;
  localparam int TABLE_LEN  = 24;

  localparam int SAMPLE_W  = 16;
  localparam int HEADING_W = 16;
  localparam int DECL_W    = 16;

  localparam longint TWO_PI_Q30    = 64'sd6746518852;
  localparam longint PI_Q30        = 64'sd3373259426;
  localparam longint DECL_DEF_Q30  = 64'sd49070001;

  // round a Q30 constant to fb fraction bits, half up
  function automatic longint to_frac(input longint q30, input int fb);
    int sh;
    sh = TABLE_FRAC - fb;
    return (q30 + (64'sd1 <<< (sh - 1))) >>> sh;
  endfunction

  function automatic longint atan_q30(input int i);
    longint v;
    unique case (i)
      0:       v = 64'sd843314857;
      1:       v = 64'sd497837829;
      2:       v = 64'sd263043837;
      3:       v = 64'sd133525159;
      4:       v = 64'sd67021687;
      5:       v = 64'sd33543516;
      6:       v = 64'sd16775851;
      7:       v = 64'sd8388437;
      8:       v = 64'sd4194283;
      9:       v = 64'sd2097149;
      default: v = 64'sd1 <<< (30 - i);  // atan(2^-i) == 2^-i at this precision
    endcase
    return v;
  endfunction

  function automatic longint atan_frac(input int i, input int fb);
    return to_frac(atan_q30(i), fb);
  endfunction

endpackage

// ===== hdl/compass_heading_atan2.sv =====
// ----------------------------------------------------------------------------
// compass_heading_atan2
// Magnetometer heading: atan2(y, x) by vectoring CORDIC, plus declination,
// wrapped to [0, 2*pi], unsigned fixed point.
// ----------------------------------------------------------------------------
// One X/Y beat in, one heading beat out. The CORDIC is fully unrolled, one
// register stage per iteration, so a new reading is taken every clock cycle
// unless the output stalls. Registers in order: pre-rotation, the iterations,
// declination add, two wrap stages. Back-pressure on the output freezes the
// whole pipeline. The declination register should only be written while no
// beat is in flight.
module compass_heading_atan2
  import chatan_pkg::*;
#(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF,
  parameter int FRAC_BITS     = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [31:0]          s_tdata,   // [15:0] x_reading, [31:16] y_reading
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [HEADING_W-1:0] m_tdata,   // [15:0] heading_angle
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [DECL_W-1:0]    cfg_data
);

  localparam int N    = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;
  localparam int XY_W = SAMPLE_W + 1 + 16 + 3;     // scaled by 2^16, gain headroom
  localparam int Z_W  = FRAC_BITS + 4;
  localparam int H_W  = ((Z_W > DECL_W) ? Z_W : DECL_W) + 2;

  localparam logic signed [Z_W-1:0] PI_F     = Z_W'(to_frac(PI_Q30, FRAC_BITS));
  localparam logic signed [H_W-1:0] TWO_PI_F = H_W'(to_frac(TWO_PI_Q30, FRAC_BITS));
  localparam logic [DECL_W-1:0]     DECL_RST = DECL_W'(to_frac(DECL_DEF_Q30, FRAC_BITS));

  logic                    adv;
  logic [DECL_W-1:0]       declination;

  logic                    v_pipe [0:N];
  logic                    zr_pipe[0:N];
  logic signed [XY_W-1:0]  x_pipe [0:N];
  logic signed [XY_W-1:0]  y_pipe [0:N];
  logic signed [Z_W-1:0]   z_pipe [0:N];

  logic                    v_sum, v_wr;
  logic signed [H_W-1:0]   h_sum, h_wr, h_out;

  logic signed [SAMPLE_W:0] x_in, y_in, x_rot, y_rot;
  logic                     in_zero, in_neg;

  assign adv       = !m_tvalid || m_tready;
  assign s_tready  = adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      declination <= DECL_RST;
    end else if (cfg_valid) begin
      declination <= cfg_data;
    end
  end

  // pre-rotation: left half-plane is turned by pi
  always_comb begin
    x_in    = (SAMPLE_W+1)'($signed(s_tdata[15:0]));
    y_in    = (SAMPLE_W+1)'($signed(s_tdata[31:16]));
    in_zero = (x_in == '0) && (y_in == '0);
    in_neg  = x_in[SAMPLE_W];
    x_rot   = in_neg ? -x_in : x_in;
    y_rot   = in_neg ? -y_in : y_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_pipe[0] <= 1'b0;
    end else if (adv) begin
      v_pipe[0] <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      zr_pipe[0] <= in_zero;
      x_pipe[0]  <= {{(XY_W-SAMPLE_W-17){x_rot[SAMPLE_W]}}, x_rot, 16'b0};
      y_pipe[0]  <= {{(XY_W-SAMPLE_W-17){y_rot[SAMPLE_W]}}, y_rot, 16'b0};
      if (!in_neg) begin
        z_pipe[0] <= '0;
      end else if (y_in[SAMPLE_W]) begin
        z_pipe[0] <= -PI_F;
      end else begin
        z_pipe[0] <= PI_F;
      end
    end
  end

  for (genvar g = 0; g < N; g++) begin : g_iter
    localparam logic signed [Z_W-1:0] ATAN_G = Z_W'(atan_frac(g, FRAC_BITS));
    logic signed [XY_W-1:0] xs, ys;
    assign xs = x_pipe[g] >>> g;
    assign ys = y_pipe[g] >>> g;

    always_ff @(posedge clk) begin
      if (rst) begin
        v_pipe[g+1] <= 1'b0;
      end else if (adv) begin
        v_pipe[g+1] <= v_pipe[g];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        zr_pipe[g+1] <= zr_pipe[g];
        if (!y_pipe[g][XY_W-1]) begin
          x_pipe[g+1] <= x_pipe[g] + ys;
          y_pipe[g+1] <= y_pipe[g] - xs;
          z_pipe[g+1] <= z_pipe[g] + ATAN_G;
        end else begin
          x_pipe[g+1] <= x_pipe[g] - ys;
          y_pipe[g+1] <= y_pipe[g] + xs;
          z_pipe[g+1] <= z_pipe[g] - ATAN_G;
        end
      end
    end
  end

  // declination add, then wrap in two steps
  always_ff @(posedge clk) begin
    if (rst) begin
      v_sum    <= 1'b0;
      v_wr     <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (adv) begin
      v_sum    <= v_pipe[N];
      v_wr     <= v_sum;
      m_tvalid <= v_wr;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      h_sum <= (zr_pipe[N] ? H_W'(0) : H_W'(z_pipe[N])) + H_W'($signed(declination));
      h_wr  <= h_sum[H_W-1] ? h_sum + TWO_PI_F : h_sum;
      if (h_wr > TWO_PI_F) begin
        if (h_wr - TWO_PI_F > TWO_PI_F) begin
          h_out <= TWO_PI_F;
        end else begin
          h_out <= h_wr - TWO_PI_F;
        end
      end else if (h_wr[H_W-1]) begin
        h_out <= '0;
      end else begin
        h_out <= h_wr;
      end
    end
  end

  assign m_tdata = h_out[HEADING_W-1:0];

`ifndef SYNTHESIS
  a_heading_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (!h_out[H_W-1] && h_out <= TWO_PI_F))
    else $error("heading outside [0, 2pi]");

  a_x_positive: assert property (@(posedge clk) disable iff (rst)
    v_pipe[N] |-> !x_pipe[N][XY_W-1])
    else $error("CORDIC x went negative");

  a_stall_freezes: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> ($stable(v_pipe[N]) && $stable(v_sum) && $stable(v_wr)))
    else $error("pipeline moved during output stall");
`endif

endmodule

// ===== dv/compass_heading_atan2_tb.sv =====
// ----------------------------------------------------------------------------
// compass_heading_atan2_tb
// Self-checking bench for the compass heading CORDIC. Each X/Y beat sent in
// is turned into an expected heading by a bit-exact fixed-point model of the
// vectoring CORDIC, declination add and wrap. Output beats are compared in
// order against those expectations. Covers axis and corner readings, all
// declination extremes (including out-of-range values, which can saturate), long
// output stalls that fill the pipe, and random traffic with bursty input and
// patterned back-pressure.
// ----------------------------------------------------------------------------
module compass_heading_atan2_tb;

  localparam int STAGES       = 16;
  localparam int FRAC         = 13;
  localparam int ATAN_ENTRIES = 24;
  localparam int ANGLE_SHIFT  = 30 - FRAC;
  localparam int LATENCY      = STAGES + 4;
  localparam int HOLD_CYCLES  = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int MAX_REPORTS  = 30;

  localparam longint TWO_PI_RAD_Q30 = 64'sd6746518852;
  localparam longint PI_RAD_Q30     = 64'sd3373259426;
  localparam longint DECL_RESET_Q30 = 64'sd49070001;

  localparam logic signed [15:0] DECL_MIN = -16'sd25736;
  localparam logic signed [15:0] DECL_MAX = 16'sd25735;

  typedef struct packed {
    logic signed [15:0] y;
    logic signed [15:0] x;
  } reading_t;

  typedef enum logic [1:0] {SINK_ALWAYS, SINK_RANDOM, SINK_PATTERN} sink_mode_t;

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              s_tvalid = 1'b0;
  logic                              s_tready;
  logic [31:0]                       s_tdata = '0;   // [15:0] x_reading, [31:16] y_reading
  logic                              m_tvalid;
  logic                              m_tready = 1'b0;
  logic [chatan_pkg::HEADING_W-1:0]  m_tdata;        // [15:0] heading_angle
  logic                              cfg_valid = 1'b0;
  logic                              cfg_ready;
  logic [chatan_pkg::DECL_W-1:0]     cfg_data = '0;

  logic [15:0]        pending_headings[$];
  logic signed [15:0] declination_shadow;
  int                 errors = 0;
  int                 idle_cycles = 0;
  int                 burst_left = 0;
  bit                 sender_gaps = 1'b0;
  sink_mode_t         sink_mode = SINK_ALWAYS;
  logic [15:0]        stall_pattern = 16'hffff;
  logic [15:0]        pattern_seed = 16'hffff;
  bit                 pattern_req = 1'b0;
  bit                 hold_req = 1'b0;
  int                 hold_left = 0;

  compass_heading_atan2 #(
    .CORDIC_STAGES(STAGES),
    .FRAC_BITS    (FRAC)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------- model

  function automatic longint q30_to_angle(input longint q);
    return (q + (64'sd1 <<< (ANGLE_SHIFT - 1))) >>> ANGLE_SHIFT;
  endfunction

  // atan(2^-k) in Q30; beyond k = 9 it equals 2^-k at this precision
  function automatic longint arctan_q30(input int k);
    longint v;
    case (k)
      0:       v = 64'sd843314857;
      1:       v = 64'sd497837829;
      2:       v = 64'sd263043837;
      3:       v = 64'sd133525159;
      4:       v = 64'sd67021687;
      5:       v = 64'sd33543516;
      6:       v = 64'sd16775851;
      7:       v = 64'sd8388437;
      8:       v = 64'sd4194283;
      9:       v = 64'sd2097149;
      default: v = 64'sd1 <<< (30 - k);
    endcase
    return v;
  endfunction

  function automatic logic [15:0] predict_heading(input logic signed [15:0] xr,
                                                  input logic signed [15:0] yr,
                                                  input logic signed [15:0] decl);
    longint x, y, z, xs, ys, h, two_pi;
    int k;
    x = xr;
    y = yr;
    z = 0;
    two_pi = q30_to_angle(TWO_PI_RAD_Q30);
    if (x != 0 || y != 0) begin
      // left half-plane: rotate by pi first
      if (x < 0) begin
        z = (y >= 0) ? q30_to_angle(PI_RAD_Q30) : -q30_to_angle(PI_RAD_Q30);
        x = -x;
        y = -y;
      end
      x = x * 65536;
      y = y * 65536;
      for (k = 0; k < STAGES && k < ATAN_ENTRIES; k++) begin
        xs = x >>> k;
        ys = y >>> k;
        if (y >= 0) begin
          x = x + ys;
          y = y - xs;
          z = z + q30_to_angle(arctan_q30(k));
        end else begin
          x = x - ys;
          y = y + xs;
          z = z - q30_to_angle(arctan_q30(k));
        end
      end
    end
    h = z + decl;
    if (h < 0) h = h + two_pi;
    if (h > two_pi) h = h - two_pi;
    // out-of-range declination can leave the sum outside after one wrap
    if (h < 0) h = 0;
    if (h > two_pi) h = two_pi;
    return h[15:0];
  endfunction

  // ------------------------------------------------------------- stimulus

  function automatic reading_t make_reading(input int sx, input int sy);
    reading_t r;
    r.x = sx[15:0];
    r.y = sy[15:0];
    return r;
  endfunction

  function automatic reading_t random_reading();
    reading_t r;
    int kind;
    int m;
    kind = $urandom_range(0, 9);
    r = $urandom;
    case (kind)
      6: begin
        r.x = $signed(16'($urandom_range(0, 30))) - 16'sd15;
        r.y = $signed(16'($urandom_range(0, 30))) - 16'sd15;
      end
      7: if ($urandom_range(0, 1)) r.x = '0; else r.y = '0;
      8: begin
        r.x = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
        r.y = $urandom_range(0, 2) == 0 ? 16'sh0000 :
              ($urandom_range(0, 1) ? 16'sh7fff : 16'sh8000);
      end
      9: begin
        m = $urandom_range(1, 32767);
        r.x = $urandom_range(0, 1) ? m[15:0] : -m[15:0];
        r.y = $urandom_range(0, 1) ? m[15:0] : -m[15:0];
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_reading(input reading_t r);
    int gap;
    if (sender_gaps && burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap = $urandom_range(0, 5);
      if (gap > 0) begin
        @(negedge clk);
        s_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= r;
    do @(posedge clk); while (!s_tready);
    pending_headings.push_back(predict_heading(r.x, r.y, declination_shadow));
  endtask

  task automatic wait_idle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_headings.size() != 0) @(posedge clk);
  endtask

  task automatic write_declination(input logic signed [15:0] value);
    wait_idle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    declination_shadow = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // --------------------------------------------------------------- sink

  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (pattern_req) begin
      stall_pattern <= pattern_seed;
      pattern_req = 1'b0;
    end else begin
      stall_pattern <= {stall_pattern[0], stall_pattern[15:1]};
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      case (sink_mode)
        SINK_RANDOM:  m_tready <= ($urandom_range(0, 99) >= 30);
        SINK_PATTERN: m_tready <= stall_pattern[0];
        default:      m_tready <= 1'b1;
      endcase
    end
  end

  // ---------------------------------------------------- result checking

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    if (errors < MAX_REPORTS)
      $display("mismatch: %s heading got %0d expected %0d", what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_headings.size() == 0)
        report_mismatch("unexpected beat,", m_tdata, 16'd0);
      else if (m_tdata !== pending_headings[0])
        report_mismatch("wrong", m_tdata, pending_headings.pop_front());
      else
        void'(pending_headings.pop_front());
    end
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else if (pending_headings.size() != 0 || s_tvalid || cfg_valid)
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------- tests

  task automatic test_default_declination();
    reading_t probes[$];
    probes = '{make_reading(0, 0), make_reading(32767, 0), make_reading(-32768, 0),
               make_reading(0, 32767), make_reading(0, -32768), make_reading(-1, 0),
               make_reading(-1, -1), make_reading(-1, 1), make_reading(32767, 32767),
               make_reading(-32768, -32768), make_reading(32767, -32768),
               make_reading(-32768, 32767), make_reading(1, 0), make_reading(0, 1),
               make_reading(0, -1), make_reading(1, -1), make_reading(-32768, -1),
               make_reading(5, -3), make_reading(-7, 3), make_reading(100, 100)};
    sink_mode = SINK_ALWAYS;
    sender_gaps = 1'b0;
    foreach (probes[i]) send_reading(probes[i]);
    wait_idle();
  endtask

  // offsets at and beyond the stated range; the beyond values can force saturation
  task automatic test_declination_extremes();
    logic signed [15:0] offsets[$];
    reading_t probes[$];
    offsets = '{DECL_MIN, DECL_MAX, -16'sd32768, 16'sd32767, 16'sd0,
                16'($urandom_range(0, 65535))};
    probes = '{make_reading(0, 0), make_reading(-1, 0), make_reading(-32768, -1),
               make_reading(1, 0), make_reading(0, -1), make_reading(-100, -1)};
    sink_mode = SINK_RANDOM;
    foreach (offsets[j]) begin
      write_declination(offsets[j]);
      foreach (probes[i]) send_reading(probes[i]);
      send_reading(random_reading());
    end
    wait_idle();
  endtask

  // sink holds off long enough for the pipe to fill and stall the input
  task automatic test_output_hold_off();
    write_declination($signed(16'($urandom_range(0, 51471))) + DECL_MIN);
    sink_mode = SINK_RANDOM;
    sender_gaps = 1'b0;
    for (int i = 0; i < 80; i++) begin
      if (i == 10) hold_req = 1'b1;
      send_reading(random_reading());
    end
    wait_idle();
  endtask

  task automatic test_random_traffic();
    logic signed [15:0] offset;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: offset = 16'(q30_to_angle(DECL_RESET_Q30));
        1: offset = $signed(16'($urandom_range(0, 51471))) + DECL_MIN;
        2: offset = 16'($urandom_range(0, 65535));
        default: offset = 16'sd0;
      endcase
      write_declination(offset);
      sink_mode     = (phase == 0) ? SINK_ALWAYS : (phase == 2) ? SINK_PATTERN : SINK_RANDOM;
      sender_gaps   = (phase != 0);
      // at least one ready slot per rotation so the sink never locks up
      pattern_seed  = 16'($urandom) | 16'h0001;
      pattern_req   = 1'b1;
      for (int i = 0; i < 345; i++) send_reading(random_reading());
    end
    wait_idle();
  endtask

  initial begin
    declination_shadow = 16'(q30_to_angle(DECL_RESET_Q30));
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_default_declination();
    test_declination_extremes();
    test_output_hold_off();
    test_random_traffic();

    wait_idle();
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0 && pending_headings.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
